/* rtl/ppws_pkg.sv */
// ----------------------------------------------------------------------------
// ppws_pkg: shared types and constants
// Field widths, register reset value and the control word handed from the
// measurement stage to the period chain.
// ----------------------------------------------------------------------------
package ppws_pkg;

  localparam int EDGE_W  = 32;
  localparam int THR_W   = 20;
  localparam int SUM_W   = 35;
  localparam int COUNT_W = 3;

  localparam logic [THR_W-1:0] THRESH_RESET = 20'hC00;

  typedef struct packed {
    logic load;
    logic store;
  } chain_ctl_t;

endpackage

/* rtl/ppws_cell.sv */
// ----------------------------------------------------------------------------
// ppws_cell: one period cell
// Holds one stored period and its valid flag; on shift, takes the word of its
// upstream neighbor.
// ----------------------------------------------------------------------------
module ppws_cell #(
  parameter int W = 32
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         shift,
  input  logic [W-1:0] prev_val,
  input  logic         prev_vld,
  output logic [W-1:0] val,
  output logic         vld
);

  logic [W-1:0] val_r;
  logic         vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (shift) begin
      vld_r <= prev_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      val_r <= prev_val;
    end
  end

  assign val = val_r;
  assign vld = vld_r;

endmodule

/* rtl/ppws_chain.sv */
// ----------------------------------------------------------------------------
// ppws_chain: row of period cells with running sum and count
// A stored period enters the head cell, every cell hands its word on, and the
// tail word drops out; sum and count follow the words that enter and leave.
// ----------------------------------------------------------------------------
module ppws_chain import ppws_pkg::*; #(
  parameter  int RING_DEPTH = 5,
  parameter  int TIME_WIDTH = 32,
  localparam int CNT_W      = $clog2(RING_DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  chain_ctl_t            ctl,
  input  logic [TIME_WIDTH-1:0] period,
  output logic [SUM_W-1:0]      sum_nxt,
  output logic [CNT_W-1:0]      count_nxt
);

  logic [TIME_WIDTH-1:0] cell_val [RING_DEPTH];
  logic                  cell_vld [RING_DEPTH];
  logic                  shift;
  logic [SUM_W-1:0]      sum_r;
  logic [CNT_W-1:0]      count_r;
  logic [SUM_W-1:0]      tail_term;

  assign shift = ctl.load && ctl.store;

  for (genvar i = 0; i < RING_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_head
      ppws_cell #(.W(TIME_WIDTH)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift    (shift),
        .prev_val (period),
        .prev_vld (1'b1),
        .val      (cell_val[i]),
        .vld      (cell_vld[i])
      );
    end else begin : g_body
      ppws_cell #(.W(TIME_WIDTH)) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .shift    (shift),
        .prev_val (cell_val[i-1]),
        .prev_vld (cell_vld[i-1]),
        .val      (cell_val[i]),
        .vld      (cell_vld[i])
      );
    end
  end

  assign tail_term = cell_vld[RING_DEPTH-1] ? SUM_W'(cell_val[RING_DEPTH-1]) : '0;

  always_comb begin
    sum_nxt   = sum_r;
    count_nxt = count_r;
    if (shift) begin
      sum_nxt = sum_r + SUM_W'(period) - tail_term;
      if (!cell_vld[RING_DEPTH-1]) begin
        count_nxt = count_r + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r   <= '0;
      count_r <= '0;
    end else begin
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
    end
  end

endmodule

/* rtl/pulse_period_window_sum_unit.sv */
// ----------------------------------------------------------------------------
// pulse_period_window_sum_unit: tachometer pulse-period moving sum
// Takes one edge timestamp per word and returns the sum and count of the
// last RING_DEPTH accepted pulse periods with reject and first-edge flags.
// ----------------------------------------------------------------------------
// Each word first has its period formed and compared with the glitch
// threshold, and both are registered; as the word moves to the output
// register, the period chain moves and the running sum is updated. A new
// word is accepted every cycle while the result side takes words; the output
// register lets the next word in while a result waits. The threshold register
// is written through the cfg channel, which is always ready.
module pulse_period_window_sum_unit import ppws_pkg::*; #(
  parameter int RING_DEPTH = 5,
  parameter int TIME_WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [EDGE_W-1:0]  in_edge_time,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [SUM_W-1:0]   out_period_sum,
  output logic [COUNT_W-1:0] out_period_count,
  output logic               out_rejected,
  output logic               out_first_edge,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [THR_W-1:0]   cfg_data
);

  localparam int CNT_W = $clog2(RING_DEPTH + 1);
  localparam int CMP_W = (TIME_WIDTH > THR_W) ? TIME_WIDTH : THR_W;

  logic [THR_W-1:0]      thr_r;
  logic [TIME_WIDTH-1:0] last_edge_r;
  logic                  have_prev_r;

  logic                  a_valid_r;
  logic [TIME_WIDTH-1:0] a_period_r;
  logic                  a_store_r;
  logic                  a_rej_r;
  logic                  a_first_r;

  logic                  out_valid_r;
  logic [SUM_W-1:0]      out_sum_r;
  logic [COUNT_W-1:0]    out_count_r;
  logic                  out_rej_r;
  logic                  out_first_r;

  logic                  in_acc;
  logic                  b_load;
  logic [TIME_WIDTH-1:0] now;
  logic [TIME_WIDTH-1:0] diff;
  logic                  store_nxt;
  chain_ctl_t            ctl;
  logic [SUM_W-1:0]      sum_nxt;
  logic [CNT_W-1:0]      count_nxt;

  assign b_load   = a_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !a_valid_r || b_load;
  assign in_acc   = in_valid && in_ready;

  assign now       = TIME_WIDTH'(in_edge_time);
  assign diff      = now - last_edge_r;
  assign store_nxt = have_prev_r && (CMP_W'(diff) > CMP_W'(thr_r));

  // hold the threshold; always ready
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr_r <= cfg_data;
    end
  end

  // re-anchor on every edge
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_edge_r <= '0;
      have_prev_r <= 1'b0;
    end else if (in_acc) begin
      last_edge_r <= now;
      have_prev_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (in_acc) begin
      a_valid_r <= 1'b1;
    end else if (b_load) begin
      a_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      a_period_r <= diff;
      a_store_r  <= store_nxt;
      a_rej_r    <= have_prev_r && !store_nxt;
      a_first_r  <= !have_prev_r;
    end
  end

  assign ctl.load  = b_load;
  assign ctl.store = a_store_r;

  ppws_chain #(
    .RING_DEPTH (RING_DEPTH),
    .TIME_WIDTH (TIME_WIDTH)
  ) u_chain (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .period    (a_period_r),
    .sum_nxt   (sum_nxt),
    .count_nxt (count_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_load) begin
      out_sum_r   <= sum_nxt;
      out_count_r <= COUNT_W'(count_nxt);
      out_rej_r   <= a_rej_r;
      out_first_r <= a_first_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_period_sum   = out_sum_r;
  assign out_period_count = out_count_r;
  assign out_rejected     = out_rej_r;
  assign out_first_edge   = out_first_r;

endmodule

/* rtl/ppws_checker.sv */
// ----------------------------------------------------------------------------
// ppws_checker: port-level checks for the pulse-period unit
// Watches the result channel and flags results that cannot occur.
// ----------------------------------------------------------------------------
module ppws_checker import ppws_pkg::*; #(
  parameter int RING_DEPTH = 5
) (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic [SUM_W-1:0]   out_period_sum,
  input logic [COUNT_W-1:0] out_period_count,
  input logic               out_rejected,
  input logic               out_first_edge
);

  a_first_not_rejected : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_first_edge |-> !out_rejected)
    else $error("first edge word flagged as rejected");

  a_empty_sum_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_period_count == '0 && RING_DEPTH < 8 |-> out_period_sum == '0)
    else $error("empty ring reports nonzero sum");

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> 32'(out_period_count) <= RING_DEPTH || RING_DEPTH >= 8)
    else $error("count above ring depth");

  a_out_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_period_sum)
                               && $stable(out_period_count))
    else $error("stalled result word changed");

endmodule

bind pulse_period_window_sum_unit ppws_checker #(.RING_DEPTH(RING_DEPTH)) u_ppws_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_period_sum   (out_period_sum),
  .out_period_count (out_period_count),
  .out_rejected     (out_rejected),
  .out_first_edge   (out_first_edge)
);
